@@ hdl/swmma_pkg.sv @@
package swmma_pkg;

	// field widths
	localparam int SAMPLE_W  = 12;
	localparam int GAIN_W    = 17;
	localparam int OFFSET_W  = 10;
	localparam int MV_W      = 13;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	// calibration arithmetic
	localparam int FRAC_W = 16;
	localparam int PROD_W = SAMPLE_W + GAIN_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

	// register reset values
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 17'd52980;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd40;

	// calibrated ceiling
	localparam logic [MV_W-1:0] MV_LIMIT = 13'd8191;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// running extremes handed from cell to cell
	typedef struct packed {
		sample_t lo;
		sample_t hi;
	} extreme_t;

endpackage

@@ hdl/sliding_window_min_max_avg.sv @@
// Moving-window minimum, maximum and mean of 12-bit converter samples.
// Input channel: sample with in_valid / in_ready. Output channel: min_count,
// max_count, mean_count and their calibrated millivolt values min_mv,
// max_mv, mean_mv, with out_valid / out_ready. One result word per sample.
// Configuration: cfg_we with cfg_index 0 writes gain_q16 (unsigned Q16),
// index 1 writes offset_mv; other indexes are ignored. Write only when idle.
// The window is a row of WINDOW cells that shifts once per accepted sample;
// the running extremes ripple down the row one cell per cycle, and the
// sequencer waits in its sweep state while the row settles. Meanwhile a
// reciprocal multiply forms sum / WINDOW, registering start and product.
// One shared 12x17 multiplier then calibrates the three values in turn.
// A result is loaded after the sweep and the calibration steps, and the
// next sample is taken in the cycle after that: one sample at a time.
// The output register holds a finished word while the receiver stalls; a
// new result waits in the final step until that word is taken.
// Reset clears the window and the sum to zero at once (zeros count until the
// window fills) and loads the default gain and offset.
module sliding_window_min_max_avg #(
	parameter int WINDOW = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [swmma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swmma_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  swmma_pkg::sample_t              sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output swmma_pkg::sample_t              min_count,
	output swmma_pkg::sample_t              max_count,
	output swmma_pkg::sample_t              mean_count,
	output logic [swmma_pkg::MV_W-1:0]      min_mv,
	output logic [swmma_pkg::MV_W-1:0]      max_mv,
	output logic [swmma_pkg::MV_W-1:0]      mean_mv
);
	import swmma_pkg::*;

	localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);
	localparam int SETTLE = WINDOW;
	localparam int WAIT_W = $clog2(SETTLE);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_CAL   = 2'd2;

	localparam logic [1:0] CAL_MIN  = 2'd0;
	localparam logic [1:0] CAL_MAX  = 2'd1;
	localparam logic [1:0] CAL_MEAN = 2'd2;
	localparam logic [1:0] CAL_LOAD = 2'd3;

	logic [1:0]          state_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [1:0]          cal_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_next;
	logic                accept;
	logic                out_free;
	sample_t             chain [WINDOW+1];
	extreme_t            part [WINDOW+1];
	sample_t             mean;
	sample_t             cal_in;
	logic [MV_W-1:0]     cal_mv;
	logic [MV_W-1:0]     min_mv_q;
	logic [MV_W-1:0]     max_mv_q;
	logic                out_valid_q;
	sample_t             min_count_q;
	sample_t             max_count_q;
	sample_t             mean_count_q;
	logic [MV_W-1:0]     min_out_q;
	logic [MV_W-1:0]     max_out_q;
	logic [MV_W-1:0]     mean_out_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				default:    ;
			endcase
		end
	end

	// window row: the new word enters cell 0, the oldest drops off the end
	assign chain[0]   = sample;
	assign part[0].lo = '1;
	assign part[0].hi = '0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		swmma_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (accept),
			.din    (chain[i]),
			.dout   (chain[i+1]),
			.pin    (part[i]),
			.pout   (part[i+1])
		);
	end

	// running sum: add the new word, drop the oldest
	assign sum_next = sum_q - SUM_W'(chain[WINDOW]) + SUM_W'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= sum_next;
		end
	end

	swmma_div #(
		.DIVISOR (WINDOW),
		.DVD_W   (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (sum_q),
		.quotient (mean)
	);

	// pick the value to calibrate this step
	always_comb begin
		case (cal_q)
			CAL_MIN: cal_in = part[WINDOW].lo;
			CAL_MAX: cal_in = part[WINDOW].hi;
			default: cal_in = mean;
		endcase
	end

	swmma_cal u_cal (
		.clk    (clk),
		.count  (cal_in),
		.gain   (gain_q),
		.offset (offset_q),
		.mv     (cal_mv)
	);

	// sequencer: settle the row and divider, then calibrate three values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
			cal_q   <= CAL_MIN;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SWEEP;
						wait_q  <= '0;
					end
				end
				ST_SWEEP: begin
					if (wait_q == WAIT_W'(SETTLE - 1)) begin
						state_q <= ST_CAL;
						cal_q   <= CAL_MIN;
					end else begin
						wait_q <= wait_q + 1'b1;
					end
				end
				ST_CAL: begin
					if (cal_q != CAL_LOAD) begin
						cal_q <= cal_q + 1'b1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// keep the calibrated extremes as they come out
	always_ff @(posedge clk) begin
		if (state_q == ST_CAL && cal_q == CAL_MAX) begin
			min_mv_q <= cal_mv;
		end
		if (state_q == ST_CAL && cal_q == CAL_MEAN) begin
			max_mv_q <= cal_mv;
		end
	end

	// output register: load a finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_CAL && cal_q == CAL_LOAD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CAL && cal_q == CAL_LOAD && out_free) begin
			min_count_q  <= part[WINDOW].lo;
			max_count_q  <= part[WINDOW].hi;
			mean_count_q <= mean;
			min_out_q    <= min_mv_q;
			max_out_q    <= max_mv_q;
			mean_out_q   <= cal_mv;
		end
	end

	assign out_valid  = out_valid_q;
	assign min_count  = min_count_q;
	assign max_count  = max_count_q;
	assign mean_count = mean_count_q;
	assign min_mv     = min_out_q;
	assign max_mv     = max_out_q;
	assign mean_mv    = mean_out_q;

endmodule

@@ hdl/swmma_cell.sv @@
module swmma_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  swmma_pkg::sample_t  din,
	output swmma_pkg::sample_t  dout,
	input  swmma_pkg::extreme_t pin,
	output swmma_pkg::extreme_t pout
);
	import swmma_pkg::*;

	sample_t  val_q;
	extreme_t part_q;

	// hold one window entry, take the neighbour's word on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= din;
		end
	end

	// fold own entry into the extremes passed down the row
	always_ff @(posedge clk) begin
		part_q.lo <= (val_q < pin.lo) ? val_q : pin.lo;
		part_q.hi <= (val_q > pin.hi) ? val_q : pin.hi;
	end

	assign dout = val_q;
	assign pout = part_q;

endmodule

@@ hdl/swmma_div.sv @@
module swmma_div #(
	parameter int DIVISOR = 20,
	parameter int DVD_W   = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	output swmma_pkg::sample_t   quotient
);
	import swmma_pkg::*;

	// exact for every dividend below 2**DVD_W with a rounded-up reciprocal
	localparam int SHIFT = DVD_W + $clog2(DIVISOR);
	localparam int RCP_W = DVD_W + 1;
	localparam int PRD_W = DVD_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic             start_q;
	logic [PRD_W-1:0] prod_q;

	// take the settled sum in the cycle after the start, then multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			prod_q  <= '0;
		end else begin
			start_q <= start;
			if (start_q) begin
				prod_q <= PRD_W'(dividend) * PRD_W'(RECIP);
			end
		end
	end

	// the window mean never exceeds one sample's range
	assign quotient = prod_q[SHIFT +: SAMPLE_W];

endmodule

@@ hdl/swmma_cal.sv @@
module swmma_cal (
	input  logic                            clk,
	input  swmma_pkg::sample_t              count,
	input  logic [swmma_pkg::GAIN_W-1:0]    gain,
	input  logic [swmma_pkg::OFFSET_W-1:0]  offset,
	output logic [swmma_pkg::MV_W-1:0]      mv
);
	import swmma_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic [MV_W:0]     total;

	// scale the count by the Q16 gain
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(count) * PROD_W'(gain);
	end

	// drop the fraction, add the offset, clamp
	assign total = (MV_W + 1)'(prod_s1[PROD_W-1:FRAC_W]) + (MV_W + 1)'(offset);
	assign mv    = (total > {1'b0, MV_LIMIT}) ? MV_LIMIT : total[MV_W-1:0];

endmodule

@@ hdl/swmma_checker.sv @@
module swmma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] min_count,
	input logic [11:0] max_count,
	input logic [11:0] mean_count,
	input logic [12:0] min_mv,
	input logic [12:0] max_mv,
	input logic [12:0] mean_mv
);

	// one sample at a time: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after an accept");

	// a stalled result holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_count) &&
			$stable(max_count) && $stable(mean_count) && $stable(min_mv) &&
			$stable(max_mv) && $stable(mean_mv))
		else $error("stalled result changed or dropped");

	// the mean lies between the extremes
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_count <= mean_count && mean_count <= max_count)
		else $error("window statistics out of order");

endmodule

bind sliding_window_min_max_avg swmma_checker u_swmma_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.min_count  (min_count),
	.max_count  (max_count),
	.mean_count (mean_count),
	.min_mv     (min_mv),
	.max_mv     (max_mv),
	.mean_mv    (mean_mv)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import swmma_pkg::*;

	localparam int WIN          = 20;
	localparam int SETTLE       = 40;
	localparam int HOLD_LEN     = 300;
	localparam int LIMIT_CYCLES = 400000;
	localparam int IDLE_PCT     = 34;

	// indexes that decode to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef logic [MV_W-1:0] mv_t;

	typedef struct {
		sample_t lo;
		sample_t hi;
		sample_t mean;
		mv_t     lo_mv;
		mv_t     hi_mv;
		mv_t     mean_mv;
	} stats_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_GAIN;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	sample_t              sample     = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	sample_t              min_count;
	sample_t              max_count;
	sample_t              mean_count;
	mv_t                  min_mv;
	mv_t                  max_mv;
	mv_t                  mean_mv;

	// predicted window and calibration
	sample_t             win_cells [WIN];
	logic [16:0]         win_sum;
	int                  win_pos;
	logic [GAIN_W-1:0]   gain_now;
	logic [OFFSET_W-1:0] offset_now;

	stats_t pending_stats [$];

	int errors        = 0;
	int sent_count    = 0;
	int checked_count = 0;
	int setting_count = 0;
	int cycles        = 0;
	bit gaps_on       = 1'b1;
	bit stall_on      = 1'b1;
	int hold_asked    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	sample_t run_value = '0;
	int      run_left  = 0;

	sliding_window_min_max_avg #(
		.WINDOW(WIN)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.min_count (min_count),
		.max_count (max_count),
		.mean_count(mean_count),
		.min_mv    (min_mv),
		.max_mv    (max_mv),
		.mean_mv   (mean_mv)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scale a count to millivolts, truncate, add offset, clamp
	function automatic mv_t to_mv(input sample_t count);
		logic [PROD_W-1:0] prod;
		logic [MV_W:0]     total;
		prod  = PROD_W'(count) * PROD_W'(gain_now);
		total = (MV_W + 1)'(prod >> FRAC_W) + (MV_W + 1)'(offset_now);
		if (total > MV_LIMIT)
			return MV_LIMIT;
		return total[MV_W-1:0];
	endfunction

	// drop the oldest sample, insert the new one, predict the statistics
	task automatic advance_window(input sample_t s);
		stats_t  st;
		sample_t lo;
		sample_t hi;
		logic [16:0] mean;
		win_sum = win_sum - 17'(win_cells[win_pos]) + 17'(s);
		win_cells[win_pos] = s;
		win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
		lo = win_cells[0];
		hi = win_cells[0];
		for (int i = 1; i < WIN; i++) begin
			if (win_cells[i] < lo)
				lo = win_cells[i];
			if (win_cells[i] > hi)
				hi = win_cells[i];
		end
		mean       = 17'(win_sum / WIN);
		st.lo      = lo;
		st.hi      = hi;
		st.mean    = mean[SAMPLE_W-1:0];
		st.lo_mv   = to_mv(lo);
		st.hi_mv   = to_mv(hi);
		st.mean_mv = to_mv(st.mean);
		pending_stats.push_back(st);
	endtask

	// offer one word, with a random gap first, and hold it until taken
	task automatic send_sample(input sample_t s);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do
			@(posedge clk);
		while (!in_ready);
		advance_window(s);
		sent_count++;
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write one register while idle and track it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GAIN:   gain_now = data[GAIN_W-1:0];
			REG_OFFSET: offset_now = data[OFFSET_W-1:0];
			default:    ;
		endcase
		setting_count++;
		@(posedge clk);
	endtask

	// random sample, mostly single values with occasional constant runs
	function automatic sample_t pick_sample();
		if (run_left == 0) begin
			case ($urandom_range(5))
				0, 1:    run_value = sample_t'($urandom);
				2:       run_value = sample_t'($urandom_range(0, 31));
				3:       run_value = sample_t'($urandom_range(4064, 4095));
				4:       run_value = $urandom_range(1) ? '1 : '0;
				default: run_value = sample_t'($urandom_range(1984, 2112));
			endcase
			run_left = ($urandom_range(9) == 0) ? $urandom_range(5, 30) : 1;
		end
		run_left--;
		return run_value;
	endfunction

	task automatic test_reset_window();
		sample_t seq [10] = '{12'hFFF, 12'h000, 12'h001, 12'hFFE, 12'hAAA,
		                      12'h555, 12'h800, 12'h7FF, 12'hFFF, 12'hFFF};
		foreach (seq[i])
			send_sample(seq[i]);
		drain();
	endtask

	// largest and smallest gain and offset, saturation, unity gain
	task automatic test_cal_extremes();
		write_reg(REG_GAIN, 17'h1FFFF);
		write_reg(REG_OFFSET, 17'd1023);
		send_sample(12'hFFF);
		send_sample(12'h000);
		send_sample(12'h800);
		drain();
		write_reg(REG_GAIN, 17'd0);
		write_reg(REG_OFFSET, 17'd0);
		send_sample(12'hFFF);
		send_sample(12'h123);
		drain();
		write_reg(REG_GAIN, 17'h10000);
		send_sample(12'hFFF);
		send_sample(12'h001);
		drain();
	endtask

	// unused indexes and bits above a register's width must be ignored
	task automatic test_reg_decode();
		write_reg(REG_GAIN, GAIN_RESET);
		write_reg(REG_OFFSET, CFG_W'(OFFSET_RESET));
		write_reg(REG_SPARE_A, CFG_W'($urandom));
		write_reg(REG_SPARE_B, CFG_W'($urandom));
		write_reg(REG_OFFSET, 17'h1FC00 | 17'd7);
		send_sample(12'hFFF);
		send_sample(12'h3C0);
		send_sample(12'h000);
		drain();
	endtask

	// long receiver hold-off with a busy sender, then a full pause
	task automatic test_pressure();
		gaps_on = 1'b0;
		hold_asked <= hold_asked + 1;
		repeat (24) send_sample(pick_sample());
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		gaps_on = 1'b1;
		repeat (10) send_sample(pick_sample());
		drain();
	endtask

	task automatic test_random(input int count);
		repeat (count) send_sample(pick_sample());
		drain();
	endtask

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_stats.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// compare each accepted result word, then drive ready for the next cycle
	always @(posedge clk) begin
		stats_t want;
		if (out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, min %0d max %0d mean %0d",
				         $time, min_count, max_count, mean_count);
			end else begin
				want = pending_stats.pop_front();
				check_field("min_count", want.lo, min_count);
				check_field("max_count", want.hi, max_count);
				check_field("mean_count", want.mean, mean_count);
				check_field("min_mv", want.lo_mv, min_mv);
				check_field("max_mv", want.hi_mv, max_mv);
				check_field("mean_mv", want.mean_mv, mean_mv);
				checked_count++;
			end
		end
		if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		foreach (win_cells[i])
			win_cells[i] = '0;
		win_sum    = '0;
		win_pos    = 0;
		gain_now   = GAIN_RESET;
		offset_now = OFFSET_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_cal_extremes();
		test_reg_decode();
		test_pressure();

		// defaults restored, random idling on both sides
		write_reg(REG_GAIN, GAIN_RESET);
		write_reg(REG_OFFSET, CFG_W'(OFFSET_RESET));
		test_random(250);

		// full rate stretch with no idling at all
		gaps_on = 1'b0;
		stall_on <= 1'b0;
		test_random(200);
		gaps_on = 1'b1;
		stall_on <= 1'b1;

		// saturating calibration
		write_reg(REG_GAIN, 17'h1FFFF);
		write_reg(REG_OFFSET, 17'd1023);
		test_random(120);

		// assorted random settings
		repeat (4) begin
			write_reg(REG_GAIN, CFG_W'($urandom_range(0, 131071)));
			write_reg(REG_OFFSET, CFG_W'($urandom_range(0, 1023)));
			test_random(70);
		end

		$display("Sent %0d samples and checked %0d result words over %0d register writes.",
		         sent_count, checked_count, setting_count);
		$display("Covered extreme samples and gains, saturation, ignored bits and indexes, "
		         , "a long output stall and a full rate stretch.");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
hdl/swmma_pkg.sv
hdl/swmma_cell.sv
hdl/swmma_div.sv
hdl/swmma_cal.sv
hdl/sliding_window_min_max_avg.sv
hdl/swmma_checker.sv
tb/tb.sv
